### src/stx_etx_frame_receiver_assert.svh
// Assertion macros for the STX/ETX frame receiver checker.
// Included by the checker module; expects i_clk and i_rst_n in scope.
`ifndef STX_ETX_FRAME_RECEIVER_ASSERT_SVH
`define STX_ETX_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SEFR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SEFR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sefr_pkg.sv
// Shared types and constants for the STX/ETX frame receiver.
// No dependencies; imported by every module of the block but sefr_ram.
package sefr_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STX_CODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ETX_CODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd3;

    localparam logic [7:0]  RST_STX_CODE   = 8'd2;
    localparam logic [7:0]  RST_ETX_CODE   = 8'd3;
    localparam logic [15:0] RST_TIMEOUT_MS = 16'd10;
    localparam logic [6:0]  RST_MAX_LENGTH = 7'd64;

    localparam logic [15:0] GAP_MAX = 16'hFFFF;

    // input kind carried in tuser
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // frame end status
    localparam logic FRM_ETX = 1'b0;
    localparam logic FRM_CUT = 1'b1;

    typedef struct packed {
        logic gap_inc;
        logic gap_clr;
        logic ld_cmd;
        logic ld_len;
        logic frm_clr;
        logic wr_data;
        logic rd_start;
        logic cut;
        logic rd_issue;
    } t_cmd;

    typedef struct packed {
        logic is_stx;
        logic is_etx;
        logic gap_over;
        logic len_zero;
        logic data_done;
        logic rd_last;
        logic rd_ok;
    } t_status;

endpackage

### src/stx_etx_frame_receiver.sv
// STX/ETX serial frame receiver, top level.
// Input: s_axis stream of items, tuser=0 a received byte (tdata), tuser=1 a
// millisecond tick. Frames are STX, command, length, payload, ETX.
// Output: m_axis stream, one item per payload byte of a finished frame, or
// one item without data for an empty payload; tlast marks the final item.
// Config: i_cfg_we writes register i_cfg_index (0 stx_code, 1 etx_code,
// 2 timeout_ms, 3 max_length) from i_cfg_wdata.
// Throughput: while parsing, one input item per cycle. On ETX (or on an STX
// that cuts a frame short) input stalls while the payload is read out of
// the buffer RAM: each result is a RAM read followed by an output register
// load, and a new read is issued only after the previous one has been loaded.
// First result follows the ETX via the readout state, RAM read and output register.
// Reset: synchronous, active low; parser idle, registers to their defaults;
// payload RAM is not cleared and needs no clearing pass.
// Stall: when m_axis_tready is low the current result holds and readout
// pauses; once the last read is issued the parser takes input again.
module stx_etx_frame_receiver
    import sefr_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] byte_value
    input  logic                  s_axis_tuser,   // [0] req_type
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,   // [7:0] command, [15:8] data_byte,
                                                  // [21:16] byte_index, [23:22] zero
    output logic [1:0]            m_axis_tuser,   // [0] frame_status, [1] has_data
    output logic                  m_axis_tlast,   // last
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cmd       cmd;
    t_status    status;
    logic [7:0] command, data_byte;
    logic [5:0] byte_index;
    logic       frame_status, has_data;

    sefr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_req_type (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sefr_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_byte         (s_axis_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_m_valid      (m_axis_tvalid),
        .i_m_ready      (m_axis_tready),
        .o_command      (command),
        .o_frame_status (frame_status),
        .o_has_data     (has_data),
        .o_data_byte    (data_byte),
        .o_byte_index   (byte_index),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, byte_index, data_byte, command};
    assign m_axis_tuser = {has_data, frame_status};

endmodule

### src/sefr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sefr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/sefr_ctrl.sv
// Parser and readout controller for the STX/ETX frame receiver.
// Depends on sefr_pkg; drives sefr_dp through t_cmd, reads t_status.
module sefr_ctrl
    import sefr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_req_type,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMD  = 3'd1;
    localparam logic [2:0] S_LEN  = 3'd2;
    localparam logic [2:0] S_DATA = 3'd3;
    localparam logic [2:0] S_ETX  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_resume, n_resume;   // 1: a new frame was opened by STX
    logic [2:0] eff_state;
    logic       accept;
    t_cmd       cmd;

    assign o_in_ready = (r_state != S_OUT);
    assign accept     = i_in_valid && o_in_ready;

    // a stale gap drops a partial frame before the byte is parsed
    assign eff_state = (i_status.gap_over && r_state != S_IDLE) ? S_IDLE : r_state;

    always_comb begin
        cmd      = '0;
        n_state  = r_state;
        n_resume = r_resume;
        if (r_state == S_OUT) begin
            if (i_status.rd_ok) begin
                cmd.rd_issue = 1'b1;
                if (i_status.rd_last) begin
                    n_state     = r_resume ? S_CMD : S_IDLE;
                    cmd.frm_clr = r_resume;
                end
            end
        end else if (accept && i_req_type == REQ_TICK) begin
            cmd.gap_inc = 1'b1;
        end else if (accept) begin
            cmd.gap_clr = 1'b1;
            case (eff_state)
                S_CMD: begin
                    cmd.ld_cmd = 1'b1;
                    n_state    = S_LEN;
                end
                S_LEN: begin
                    cmd.ld_len = 1'b1;
                    n_state    = i_status.len_zero ? S_ETX : S_DATA;
                end
                S_DATA: begin
                    cmd.wr_data = 1'b1;
                    n_state     = i_status.data_done ? S_ETX : S_DATA;
                end
                S_ETX: begin
                    if (i_status.is_etx) begin
                        cmd.rd_start = 1'b1;
                        cmd.cut      = FRM_ETX;
                        n_resume     = 1'b0;
                        n_state      = S_OUT;
                    end else if (i_status.is_stx) begin
                        cmd.rd_start = 1'b1;
                        cmd.cut      = FRM_CUT;
                        n_resume     = 1'b1;
                        n_state      = S_OUT;
                    end else begin
                        n_state = S_ETX;
                    end
                end
                default: begin
                    if (i_status.is_stx) begin
                        cmd.frm_clr = 1'b1;
                        n_state     = S_CMD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_resume <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_resume <= n_resume;
        end
    end

endmodule

### src/sefr_dp.sv
// Datapath for the STX/ETX frame receiver: config registers, gap counter,
// frame registers, payload RAM, readout stage and output register.
// Depends on sefr_pkg and sefr_ram.
module sefr_dp
    import sefr_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_byte,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_m_valid,
    input  logic                  i_m_ready,
    output logic [7:0]            o_command,
    output logic                  o_frame_status,
    output logic                  o_has_data,
    output logic [7:0]            o_data_byte,
    output logic [5:0]            o_byte_index,
    output logic                  o_last
);

    localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int LEN_W  = $clog2(BUFFER_DEPTH + 1);
    localparam logic [7:0] DEPTH_B = 8'(BUFFER_DEPTH);

    // configuration
    logic [7:0]  r_stx, r_etx;
    logic [15:0] r_timeout;
    logic [6:0]  r_max_len;

    // parser state
    logic [15:0]      r_gap;
    logic [7:0]       r_fcmd;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_rcvd;

    // readout
    logic [ADDR_W-1:0] r_rd_idx;
    logic              r_cut;
    logic              r_pend_valid;
    logic [ADDR_W-1:0] r_pend_idx;
    logic              r_pend_last;
    logic              r_pend_has;
    logic [7:0]        r_pend_cmd;
    logic              r_pend_cut;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_cmd;
    logic       r_out_cut;
    logic       r_out_has;
    logic [7:0] r_out_data;
    logic [5:0] r_out_idx;
    logic       r_out_last;

    logic [7:0]       limit8, len8;
    logic [LEN_W:0]   rcvd_inc, rd_inc;
    logic [7:0]       ram_rdata;
    logic             ram_we;

    assign limit8   = ({1'b0, r_max_len} < DEPTH_B) ? {1'b0, r_max_len} : DEPTH_B;
    assign len8     = (i_byte < limit8) ? i_byte : limit8;
    assign rcvd_inc = {1'b0, r_rcvd} + (LEN_W+1)'(1);
    assign rd_inc   = {1'b0, LEN_W'(r_rd_idx)} + (LEN_W+1)'(1);
    assign ram_we   = i_cmd.wr_data && (r_rcvd < LEN_W'(BUFFER_DEPTH));

    assign o_status.is_stx    = (i_byte == r_stx);
    assign o_status.is_etx    = (i_byte == r_etx);
    assign o_status.gap_over  = (r_gap > r_timeout);
    assign o_status.len_zero  = (len8 == 8'd0);
    assign o_status.data_done = (rcvd_inc >= {1'b0, r_len});
    assign o_status.rd_last   = (r_len == '0) || (rd_inc == {1'b0, r_len});
    assign o_status.rd_ok     = !r_pend_valid && (!r_out_valid || i_m_ready);

    sefr_ram #(
        .WIDTH  (8),
        .DEPTH  (BUFFER_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ADDR_W'(r_rcvd)),
        .i_wdata (i_byte),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stx     <= RST_STX_CODE;
            r_etx     <= RST_ETX_CODE;
            r_timeout <= RST_TIMEOUT_MS;
            r_max_len <= RST_MAX_LENGTH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STX_CODE:   r_stx     <= i_cfg_wdata[7:0];
                CFG_ETX_CODE:   r_etx     <= i_cfg_wdata[7:0];
                CFG_TIMEOUT_MS: r_timeout <= i_cfg_wdata[15:0];
                CFG_MAX_LENGTH: r_max_len <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap        <= '0;
            r_fcmd       <= '0;
            r_len        <= '0;
            r_rcvd       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.gap_inc && r_gap != GAP_MAX) begin
                r_gap <= r_gap + 16'd1;
            end else if (i_cmd.gap_clr) begin
                r_gap <= '0;
            end
            if (i_cmd.frm_clr) begin
                r_fcmd <= '0;
                r_len  <= '0;
                r_rcvd <= '0;
            end else begin
                if (i_cmd.ld_cmd) begin
                    r_fcmd <= i_byte;
                end
                if (i_cmd.ld_len) begin
                    r_len <= LEN_W'(len8);
                end
                if (i_cmd.wr_data) begin
                    r_rcvd <= rcvd_inc[LEN_W-1:0];
                end
            end
            r_pend_valid <= i_cmd.rd_issue;
            r_out_valid  <= r_pend_valid || (r_out_valid && !i_m_ready);
        end
    end

    // readout payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start) begin
            r_rd_idx <= '0;
            r_cut    <= i_cmd.cut;
        end else if (i_cmd.rd_issue) begin
            r_rd_idx <= rd_inc[ADDR_W-1:0];
        end
        if (i_cmd.rd_issue) begin
            r_pend_idx  <= r_rd_idx;
            r_pend_last <= o_status.rd_last;
            r_pend_has  <= (r_len != '0);
            r_pend_cmd  <= r_fcmd;
            r_pend_cut  <= r_cut;
        end
        if (r_pend_valid) begin
            r_out_cmd  <= r_pend_cmd;
            r_out_cut  <= r_pend_cut;
            r_out_has  <= r_pend_has;
            r_out_data <= r_pend_has ? ram_rdata : 8'd0;
            r_out_idx  <= r_pend_has ? 6'(r_pend_idx) : 6'd0;
            r_out_last <= r_pend_last;
        end
    end

    assign o_m_valid      = r_out_valid;
    assign o_command      = r_out_cmd;
    assign o_frame_status = r_out_cut;
    assign o_has_data     = r_out_has;
    assign o_data_byte    = r_out_data;
    assign o_byte_index   = r_out_idx;
    assign o_last         = r_out_last;

endmodule

### src/sefr_checker.sv
// Port-level checker for the STX/ETX frame receiver, bound to the top level.
// Depends on sefr_pkg and stx_etx_frame_receiver_assert.svh.
`include "stx_etx_frame_receiver_assert.svh"

module sefr_checker
    import sefr_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [23:0]           m_axis_tdata,
    input logic [1:0]            m_axis_tuser,
    input logic                  m_axis_tlast
);

    logic        out_stall;
    logic        run_take;
    logic        out_empty;
    logic        pay_zero;
    logic [27:0] out_word;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign run_take  = m_axis_tvalid && m_axis_tready && !m_axis_tlast;
    assign out_empty = m_axis_tvalid && !m_axis_tuser[1];
    assign pay_zero  = (m_axis_tdata[21:8] == 14'd0);
    assign out_word  = {m_axis_tvalid, m_axis_tlast, m_axis_tuser, m_axis_tdata};

    // a stalled result holds its contents
    `SEFR_ASSERT_NXT(a_out_hold, out_stall, $stable(out_word), "held result changed")

    // a result without payload is the whole frame
    `SEFR_ASSERT_IMP(a_empty_last, out_empty, m_axis_tlast, "empty result not marked last")

    // a result without payload carries zero data and index
    `SEFR_ASSERT_IMP(a_empty_zero, out_empty, pay_zero, "empty result carries data")

    // the final read is not yet issued while a non-last result goes out
    `SEFR_ASSERT_IMP(a_run_in_hold, run_take, !s_axis_tready, "input taken during readout")

    // results of one frame share the command
    `SEFR_ASSERT_NXT(a_run_cmd, run_take, $stable(m_axis_tdata[7:0]), "command changed in frame")

endmodule

bind stx_etx_frame_receiver sefr_checker u_sefr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### sim/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for stx_etx_frame_receiver: directed frame cases, then random frames.
// A local parser model predicts every result. Depends on sefr_pkg and the RTL only.
module tb;
    import sefr_pkg::*;

    localparam int DEPTH         = BUFFER_DEPTH_DEF;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 420;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_PRINTS    = 40;

    typedef enum logic [2:0] {
        PS_IDLE, PS_CMD, PS_LEN, PS_DATA, PS_ETX
    } t_parse_st;

    typedef struct packed {
        logic [7:0] command;
        logic       frame_status;
        logic       has_data;
        logic [7:0] data_byte;
        logic [5:0] byte_index;
        logic       last;
    } t_frame_beat;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;    // [7:0] byte_value
    logic                  s_axis_tuser;    // [0] req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;    // [7:0] command, [15:8] data_byte,
                                            // [21:16] byte_index, [23:22] zero
    logic [1:0]            m_axis_tuser;    // [0] frame_status, [1] has_data
    logic                  m_axis_tlast;    // last
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    stx_etx_frame_receiver #(
        .BUFFER_DEPTH(DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // parser model state and register copies
    t_parse_st   rx_state;
    logic [7:0]  frm_cmd;
    logic [6:0]  frm_len;
    logic [6:0]  frm_rcvd;
    logic [7:0]  payload_mem [DEPTH];
    logic [15:0] gap_ticks;
    logic [7:0]  cfg_stx;
    logic [7:0]  cfg_etx;
    logic [15:0] cfg_timeout;
    logic [6:0]  cfg_max_len;

    t_frame_beat expected_beats[$];

    int unsigned cycle_count      = 0;
    int unsigned err_count        = 0;
    int unsigned items_sent       = 0;
    int unsigned frames_predicted = 0;
    int unsigned beats_checked    = 0;
    int unsigned settings_used    = 0;
    logic        src_idle_on      = 1'b1;
    logic        sink_stall_on    = 1'b1;
    logic        frame_open       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Timeout after %0d cycles, %0d results still due",
                 cycle_count, expected_beats.size());
        $display("Regression FAIL");
        $finish;
    end

    // ---------------- prediction ----------------

    function automatic void start_frame();
        rx_state = PS_CMD;
        frm_cmd  = '0;
        frm_len  = '0;
        frm_rcvd = '0;
    endfunction

    function automatic void emit_frame(input logic status);
        t_frame_beat b;
        int unsigned n;
        n = (frm_len > DEPTH) ? DEPTH : frm_len;
        b = '0;
        b.command      = frm_cmd;
        b.frame_status = status;
        if (n == 0) begin
            b.last = 1'b1;
            expected_beats.push_back(b);
        end else begin
            for (int k = 0; k < n; k++) begin
                b.has_data   = 1'b1;
                b.data_byte  = payload_mem[k];
                b.byte_index = k[5:0];
                b.last       = (k == n - 1);
                expected_beats.push_back(b);
            end
        end
        frames_predicted++;
    endfunction

    function automatic void predict_item(input logic kind, input logic [7:0] c);
        logic [6:0] lim;
        if (kind == REQ_TICK) begin
            if (gap_ticks != GAP_MAX) gap_ticks++;
            return;
        end
        // stale partial frame is dropped before this byte is parsed
        if (gap_ticks > cfg_timeout && rx_state != PS_IDLE) rx_state = PS_IDLE;
        gap_ticks = '0;
        case (rx_state)
            PS_CMD: begin
                frm_cmd  = c;
                rx_state = PS_LEN;
            end
            PS_LEN: begin
                lim      = (cfg_max_len > DEPTH) ? 7'(DEPTH) : cfg_max_len;
                frm_len  = (c < lim) ? c[6:0] : lim;
                rx_state = (frm_len != 0) ? PS_DATA : PS_ETX;
            end
            PS_DATA: begin
                if (frm_rcvd < DEPTH) payload_mem[frm_rcvd[5:0]] = c;
                frm_rcvd++;
                if (frm_rcvd >= frm_len) rx_state = PS_ETX;
            end
            PS_ETX: begin
                // ETX test first: with equal codes the byte ends the frame
                if (c == cfg_etx) begin
                    emit_frame(FRM_ETX);
                    rx_state = PS_IDLE;
                end else if (c == cfg_stx) begin
                    emit_frame(FRM_CUT);
                    start_frame();
                end
            end
            default: begin
                if (c == cfg_stx) start_frame();
            end
        endcase
    endfunction

    // ---------------- result checking ----------------

    task automatic report_mismatch(input string what, input int got, input int exp);
        if (err_count < MAX_PRINTS)
            $display("MISMATCH @%0d: %s got 0x%0h expected 0x%0h",
                     cycle_count, what, got, exp);
        err_count++;
    endtask

    task automatic check_beat();
        t_frame_beat got;
        t_frame_beat exp;
        got.command      = m_axis_tdata[7:0];
        got.data_byte    = m_axis_tdata[15:8];
        got.byte_index   = m_axis_tdata[21:16];
        got.frame_status = m_axis_tuser[0];
        got.has_data     = m_axis_tuser[1];
        got.last         = m_axis_tlast;
        if (expected_beats.size() == 0) begin
            report_mismatch("unexpected result, command", got.command, 0);
            return;
        end
        exp = expected_beats.pop_front();
        beats_checked++;
        if (got.command != exp.command)
            report_mismatch("command", got.command, exp.command);
        if (got.frame_status != exp.frame_status)
            report_mismatch("frame_status", got.frame_status, exp.frame_status);
        if (got.has_data != exp.has_data)
            report_mismatch("has_data", got.has_data, exp.has_data);
        if (got.data_byte != exp.data_byte)
            report_mismatch("data_byte", got.data_byte, exp.data_byte);
        if (got.byte_index != exp.byte_index)
            report_mismatch("byte_index", got.byte_index, exp.byte_index);
        if (got.last != exp.last)
            report_mismatch("last", got.last, exp.last);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_beat();
        m_axis_tready <= !(sink_stall_on && $urandom_range(99) < 11);
    end

    // ---------------- stimulus helpers ----------------

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255, 0));
    endfunction

    task automatic send_item(input logic kind, input logic [7:0] val);
        while (src_idle_on && $urandom_range(99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_item(kind, val);
        items_sent++;
    endtask

    task automatic send_bytes(input logic [7:0] seq[$]);
        foreach (seq[i]) send_item(REQ_BYTE, seq[i]);
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_item(REQ_TICK, rand_byte());
    endtask

    // hold the input until every predicted result has come out
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_beats.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_STX_CODE:   cfg_stx     = val[7:0];
            CFG_ETX_CODE:   cfg_etx     = val[7:0];
            CFG_TIMEOUT_MS: cfg_timeout = val;
            CFG_MAX_LENGTH: cfg_max_len = val[6:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(input logic [7:0] stx, input logic [7:0] etx,
                                input logic [15:0] tmo, input logic [6:0] maxl);
        write_reg(CFG_STX_CODE, {8'h00, stx});
        write_reg(CFG_ETX_CODE, {8'h00, etx});
        write_reg(CFG_TIMEOUT_MS, tmo);
        write_reg(CFG_MAX_LENGTH, {9'h000, maxl});
        settings_used++;
    endtask

    // ---------------- directed tests ----------------

    task automatic test_basic_frames();
        // junk in idle, empty payload, extreme command and data values,
        // and a stray byte while waiting for the end code
        send_bytes('{8'h00, RST_STX_CODE, 8'h00, 8'h00, RST_ETX_CODE});
        send_bytes('{RST_STX_CODE, 8'hFF, 8'h02, 8'h00, 8'hFF, 8'h55, RST_ETX_CODE});
        settle();
    endtask

    task automatic test_cut_short();
        send_bytes('{RST_STX_CODE, 8'h81, 8'h01, 8'hAA, RST_STX_CODE,
                     8'h42, 8'h00, RST_ETX_CODE});
        settle();
    endtask

    task automatic test_length_limit();
        write_reg(CFG_MAX_LENGTH, 16'd3);
        send_bytes('{RST_STX_CODE, 8'h10, 8'd200, 8'h01, 8'h02, 8'h03, RST_ETX_CODE});
        settle();
        write_reg(CFG_MAX_LENGTH, 16'd1);
        send_bytes('{RST_STX_CODE, 8'h11, 8'hFF, 8'h5A, RST_ETX_CODE});
        settle();
        write_reg(CFG_MAX_LENGTH, {9'h000, RST_MAX_LENGTH});
    endtask

    task automatic test_timeout();
        write_reg(CFG_TIMEOUT_MS, 16'd2);
        send_bytes('{RST_STX_CODE, 8'h21});
        send_ticks(3);                      // gap over the limit: frame dropped
        send_bytes('{RST_STX_CODE, 8'h22, 8'h00});
        send_ticks(2);                      // exactly at the limit: kept
        send_bytes('{RST_ETX_CODE});
        settle();
        write_reg(CFG_TIMEOUT_MS, 16'd0);
        send_bytes('{RST_STX_CODE});
        send_ticks(1);
        send_bytes('{8'h30, RST_STX_CODE, 8'h31, 8'h00, RST_ETX_CODE});
        settle();
        write_reg(CFG_TIMEOUT_MS, 16'hFFFF);
        send_bytes('{RST_STX_CODE, 8'h40});
        send_ticks(20);
        send_bytes('{8'h00, RST_ETX_CODE});
        settle();
    endtask

    task automatic test_shared_code();
        load_setting(8'h7E, 8'h7E, RST_TIMEOUT_MS, 7'd64);
        send_bytes('{8'h7E, 8'h60, 8'h01, 8'h7E, 8'h7E, 8'h7E, 8'h61, 8'h00, 8'h7E});
        settle();
    endtask

    // ---------------- random test ----------------

    task automatic maybe_ticks();
        int unsigned n;
        if ($urandom_range(99) >= 15) return;
        n = (cfg_timeout < 8) ? $urandom_range(cfg_timeout + 1, 0) : $urandom_range(4, 1);
        send_ticks(n);
    endtask

    task automatic send_random_frame();
        int unsigned roll;
        int unsigned n_pay;
        logic [7:0]  len_byte;
        logic [6:0]  lim;
        roll = $urandom_range(99);
        if (roll < 5 && !frame_open) begin
            repeat ($urandom_range(4, 1)) send_item(REQ_BYTE, rand_byte());
            return;
        end
        if (!frame_open) begin
            maybe_ticks();
            send_item(REQ_BYTE, cfg_stx);
        end
        frame_open = 1'b0;
        maybe_ticks();
        send_item(REQ_BYTE, rand_byte());
        case ($urandom_range(9))
            0:       len_byte = 8'hFF;
            1:       len_byte = rand_byte();
            default: len_byte = 8'($urandom_range(6, 0));
        endcase
        maybe_ticks();
        send_item(REQ_BYTE, len_byte);
        lim   = (cfg_max_len > DEPTH) ? 7'(DEPTH) : cfg_max_len;
        n_pay = (len_byte < lim) ? len_byte : lim;
        if (roll < 10) n_pay = $urandom_range(n_pay, 0);   // truncated frame
        for (int k = 0; k < n_pay; k++) begin
            if ($urandom_range(9) == 0) maybe_ticks();
            send_item(REQ_BYTE, rand_byte());
        end
        if (roll < 10) return;
        if ($urandom_range(9) == 0) send_item(REQ_BYTE, rand_byte());
        maybe_ticks();
        if (roll < 20) begin
            send_item(REQ_BYTE, cfg_stx);
            frame_open = 1'b1;
        end else begin
            send_item(REQ_BYTE, cfg_etx);
        end
    endtask

    task automatic test_random_frames();
        int unsigned first_item;
        int unsigned phase;
        logic [7:0]  stx;
        logic [7:0]  etx;
        logic [15:0] tmo;
        logic [6:0]  maxl;
        first_item = items_sent;
        phase      = 0;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            case (phase)
                0: load_setting(8'h00, 8'hFF, 16'hFFFF, 7'd64);
                1: load_setting(8'hFF, 8'h00, 16'h0000, 7'd1);
                default: begin
                    stx = rand_byte();
                    etx = ($urandom_range(4) == 0) ? stx : rand_byte();
                    case ($urandom_range(4))
                        0:       tmo = 16'h0000;
                        1:       tmo = 16'hFFFF;
                        2:       tmo = 16'($urandom_range(65535, 0));
                        default: tmo = 16'($urandom_range(8, 1));
                    endcase
                    case ($urandom_range(3))
                        0:       maxl = 7'd1;
                        1:       maxl = 7'd64;
                        default: maxl = 7'($urandom_range(64, 1));
                    endcase
                    load_setting(stx, etx, tmo, maxl);
                end
            endcase
            // first setting runs with both sides at full rate
            src_idle_on   = (phase != 0);
            sink_stall_on = (phase != 0);
            frame_open    = 1'b0;
            repeat (12) send_random_frame();
            settle();
            phase++;
        end
        src_idle_on   = 1'b1;
        sink_stall_on = 1'b1;
    endtask

    // ---------------- sequence ----------------

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_BYTE;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_wdata   <= '0;
        rx_state    = PS_IDLE;
        frm_cmd     = '0;
        frm_len     = '0;
        frm_rcvd    = '0;
        gap_ticks   = '0;
        cfg_stx     = RST_STX_CODE;
        cfg_etx     = RST_ETX_CODE;
        cfg_timeout = RST_TIMEOUT_MS;
        cfg_max_len = RST_MAX_LENGTH;
        foreach (payload_mem[i]) payload_mem[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_frames();
        test_cut_short();
        test_length_limit();
        test_timeout();
        test_shared_code();
        test_random_frames();

        settle();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d items (bytes and ticks) over %0d register settings",
                 items_sent, settings_used);
        $display("Predicted %0d frames, checked %0d results, %0d mismatches",
                 frames_predicted, beats_checked, err_count + expected_beats.size());
        if (err_count == 0 && expected_beats.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
